// ===== rtl/vas_pkg.sv =====
`timescale 1ns / 1ps

package vas_pkg;

   localparam int OPERATION_W = 1;
   localparam int SOUND_W     = 8;
   localparam int INDEX_W     = 3;
   localparam int SLOT_W      = 3;
   localparam int BUSY_OUT_W  = 4;
   localparam int STAMP_W     = 64;
   localparam int STEAL_W     = 32;

   localparam logic [OPERATION_W-1:0] OP_TRIGGER = 1'b0;
   localparam logic [OPERATION_W-1:0] OP_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/vas_req_if.sv =====
`timescale 1ns / 1ps

interface vas_req_if;
   import vas_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [OPERATION_W-1:0] operation;
   logic [SOUND_W-1:0]     sound_id;
   logic [INDEX_W-1:0]     voice_index;

   modport source (output valid, operation, sound_id, voice_index, input ready);
   modport sink   (input valid, operation, sound_id, voice_index, output ready);
endinterface

// ===== rtl/vas_rsp_if.sv =====
`timescale 1ns / 1ps

interface vas_rsp_if;
   import vas_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [SLOT_W-1:0]     granted_slot;
   logic [SOUND_W-1:0]    granted_sound;
   logic                  was_stolen;
   logic [STEAL_W-1:0]    steal_total;
   logic [BUSY_OUT_W-1:0] voices_busy;

   modport source (output valid, granted_slot, granted_sound, was_stolen, steal_total,
                   voices_busy, input ready);
   modport sink   (input valid, granted_slot, granted_sound, was_stolen, steal_total,
                   voices_busy, output ready);
endinterface

// ===== rtl/voice_allocator_steal_oldest.sv =====
`timescale 1ns / 1ps

// channel   dir   handshake             payload
// req_if    in    valid/ready           operation, sound_id, voice_index
// rsp_if    out   valid/ready           granted_slot, granted_sound, was_stolen,
//                                       steal_total, voices_busy
//
// a release or a trigger that finds a free voice goes straight to the finish
// state; a steal first scans the stamp memory one entry per cycle for the
// oldest stamp. reset is synchronous and needs no clearing pass. a stalled
// response holds in the output register; the next request is taken meanwhile
// and waits in the finish state until the register frees.

module voice_allocator_steal_oldest #(
   parameter int VOICE_COUNT = 8
) (
   input logic      clock,
   input logic      reset,
   vas_req_if.sink  req_if,
   vas_rsp_if.source rsp_if
);
   import vas_pkg::*;

   localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int CW = IW + 1;
   localparam int BW = $clog2(VOICE_COUNT + 1);

   state_type state_ff, state_in;

   logic [VOICE_COUNT-1:0] on_ff, on_in;
   logic [BW-1:0]          busy_ff, busy_in;
   logic [STAMP_W-1:0]     stamp_ctr_ff, stamp_ctr_in;
   logic [STEAL_W-1:0]     steal_ff, steal_in;

   logic [OPERATION_W-1:0] op_ff, op_in;
   logic [SOUND_W-1:0]     sound_ff, sound_in;
   logic [INDEX_W-1:0]     index_ff, index_in;
   logic [IW-1:0]          pick_ff, pick_in;
   logic                   stolen_ff, stolen_in;
   logic [STAMP_W-1:0]     min_ff, min_in;

   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [IW-1:0]          rd_idx_ff, rd_idx_in;
   logic [STAMP_W-1:0]     rd_data_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic [SOUND_W-1:0]     rsp_sound_ff, rsp_sound_in;
   logic                   rsp_stolen_ff, rsp_stolen_in;
   logic [STEAL_W-1:0]     rsp_steal_ff, rsp_steal_in;
   logic [BUSY_OUT_W-1:0]  rsp_busy_ff, rsp_busy_in;

   logic [STAMP_W-1:0] stamp_mem [VOICE_COUNT];

   logic          req_xfer;
   logic          out_free;
   logic          finish_go;
   logic          scan_issue;
   logic          scan_last;
   logic          any_free;
   logic [IW-1:0] free_idx;
   logic [IW-1:0] rel_idx;
   logic          rel_in_range;
   logic          mem_we;

   assign req_xfer     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign finish_go    = (state_ff == ST_FINISH) && out_free;
   assign scan_issue   = (state_ff == ST_SCAN) && (cnt_ff < CW'(VOICE_COUNT));
   assign scan_last    = rd_valid_ff && (rd_idx_ff == IW'(VOICE_COUNT - 1));
   assign rel_idx      = IW'(index_ff);
   assign rel_in_range = 32'(index_ff) < 32'(VOICE_COUNT);

   // lowest-index free voice
   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
         if (!on_ff[i]) begin
            any_free = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_if.operation == OP_TRIGGER && !any_free) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_if.ready = (state_ff == ST_IDLE);
      mem_we       = finish_go && (op_ff == OP_TRIGGER);
   end

   // datapath
   always_comb begin
      on_in         = on_ff;
      busy_in       = busy_ff;
      stamp_ctr_in  = stamp_ctr_ff;
      steal_in      = steal_ff;
      op_in         = op_ff;
      sound_in      = sound_ff;
      index_in      = index_ff;
      pick_in       = pick_ff;
      stolen_in     = stolen_ff;
      min_in        = min_ff;
      cnt_in        = cnt_ff;
      rd_valid_in   = scan_issue;
      rd_idx_in     = cnt_ff[IW-1:0];
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_sound_in  = rsp_sound_ff;
      rsp_stolen_in = rsp_stolen_ff;
      rsp_steal_in  = rsp_steal_ff;
      rsp_busy_in   = rsp_busy_ff;

      if (req_xfer) begin
         op_in     = req_if.operation;
         sound_in  = req_if.sound_id;
         index_in  = req_if.voice_index;
         pick_in   = free_idx;
         stolen_in = (req_if.operation == OP_TRIGGER) && !any_free;
         cnt_in    = '0;
      end

      if (scan_issue) begin
         cnt_in = cnt_ff + CW'(1);
      end

      // strict compare keeps the lowest index on ties
      if (rd_valid_ff && (rd_idx_ff == '0 || rd_data_ff < min_ff)) begin
         min_in  = rd_data_ff;
         pick_in = rd_idx_ff;
      end

      if (finish_go) begin
         rsp_valid_in  = 1'b1;
         rsp_stolen_in = 1'b0;
         rsp_sound_in  = '0;
         rsp_slot_in   = index_ff;
         if (op_ff == OP_TRIGGER) begin
            on_in[pick_ff] = 1'b1;
            stamp_ctr_in   = stamp_ctr_ff + STAMP_W'(1);
            rsp_slot_in    = SLOT_W'(pick_ff);
            rsp_sound_in   = sound_ff;
            rsp_stolen_in  = stolen_ff;
            if (stolen_ff) begin
               steal_in = steal_ff + STEAL_W'(1);
            end else begin
               busy_in = busy_ff + BW'(1);
            end
         end else if (rel_in_range && on_ff[rel_idx]) begin
            on_in[rel_idx] = 1'b0;
            busy_in        = busy_ff - BW'(1);
         end
         rsp_steal_in = (op_ff == OP_TRIGGER && stolen_ff) ? steal_ff + STEAL_W'(1) : steal_ff;
         rsp_busy_in  = BUSY_OUT_W'(busy_in);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         on_ff        <= '0;
         busy_ff      <= '0;
         stamp_ctr_ff <= '0;
         steal_ff     <= '0;
         cnt_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         on_ff        <= on_in;
         busy_ff      <= busy_in;
         stamp_ctr_ff <= stamp_ctr_in;
         steal_ff     <= steal_in;
         cnt_ff       <= cnt_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      sound_ff      <= sound_in;
      index_ff      <= index_in;
      pick_ff       <= pick_in;
      stolen_ff     <= stolen_in;
      min_ff        <= min_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_sound_ff  <= rsp_sound_in;
      rsp_stolen_ff <= rsp_stolen_in;
      rsp_steal_ff  <= rsp_steal_in;
      rsp_busy_ff   <= rsp_busy_in;
   end

   // stamp memory; read every cycle, but the data is used only while every voice is on, so every entry used was written
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stamp_mem[pick_ff] <= stamp_ctr_ff;
      end
      rd_data_ff <= stamp_mem[cnt_ff[IW-1:0]];
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.granted_slot  = rsp_slot_ff;
   assign rsp_if.granted_sound = rsp_sound_ff;
   assign rsp_if.was_stolen    = rsp_stolen_ff;
   assign rsp_if.steal_total   = rsp_steal_ff;
   assign rsp_if.voices_busy   = rsp_busy_ff;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import vas_pkg::*;

   localparam int VOICES          = 8;
   localparam int RANDOM_ITEMS    = 850;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int DRAIN_CYCLES    = 24;
   localparam int CYCLE_LIMIT     = 200000;

   typedef struct packed {
      logic [OPERATION_W-1:0] operation;
      logic [SOUND_W-1:0]     sound_id;
      logic [INDEX_W-1:0]     voice_index;
   } alloc_item_type;

   typedef struct packed {
      logic [SLOT_W-1:0]     granted_slot;
      logic [SOUND_W-1:0]    granted_sound;
      logic                  was_stolen;
      logic [STEAL_W-1:0]    steal_total;
      logic [BUSY_OUT_W-1:0] voices_busy;
   } voice_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vas_req_if req_chan ();
   vas_rsp_if rsp_chan ();

   voice_allocator_steal_oldest #(
      .VOICE_COUNT(VOICES)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_chan),
      .rsp_if(rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // allocator shadow state
   logic                 voice_active [VOICES];
   logic [STAMP_W-1:0]   voice_age [VOICES];
   logic [STAMP_W-1:0]   age_counter;
   logic [STEAL_W-1:0]   steal_tally;

   alloc_item_type   pending_items [$];
   voice_result_type expected_results [$];
   alloc_item_type   offered_item;

   int sent_count     = 0;
   int result_count   = 0;
   int error_count    = 0;
   int cycle_count    = 0;
   int sender_wait    = 0;
   int receiver_wait  = 0;
   bit sender_calm    = 1'b0;
   bit receiver_calm  = 1'b0;

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.operation   = OP_TRIGGER;
      req_chan.sound_id    = '0;
      req_chan.voice_index = '0;
      rsp_chan.ready       = 1'b0;
      for (int i = 0; i < VOICES; i++) begin
         voice_active[i] = 1'b0;
         voice_age[i]    = '0;
      end
      age_counter = '0;
      steal_tally = '0;
   end

   function automatic voice_result_type allocate_voice(input alloc_item_type it);
      voice_result_type   r;
      int                 pick;
      int                 busy;
      logic [STAMP_W-1:0] stamp;
      r = '0;
      if (it.operation == OP_TRIGGER) begin
         stamp       = age_counter;
         age_counter = age_counter + STAMP_W'(1);
         pick        = -1;
         for (int i = 0; i < VOICES; i++) begin
            if (!voice_active[i] && pick < 0) pick = i;
         end
         if (pick < 0) begin
            pick = 0;
            for (int i = 1; i < VOICES; i++) begin
               if (voice_age[i] < voice_age[pick]) pick = i;
            end
            steal_tally  = steal_tally + STEAL_W'(1);
            r.was_stolen = 1'b1;
         end
         voice_active[pick] = 1'b1;
         voice_age[pick]    = stamp;
         r.granted_slot     = pick[SLOT_W-1:0];
         r.granted_sound    = it.sound_id;
      end else begin
         if (it.voice_index < VOICES) voice_active[it.voice_index] = 1'b0;
         r.granted_slot = it.voice_index;
      end
      busy = 0;
      for (int i = 0; i < VOICES; i++) begin
         if (voice_active[i]) busy++;
      end
      r.steal_total = steal_tally;
      r.voices_busy = busy[BUSY_OUT_W-1:0];
      return r;
   endfunction

   task automatic queue_item(input logic [OPERATION_W-1:0] op, input logic [SOUND_W-1:0] snd,
                             input logic [INDEX_W-1:0] idx);
      alloc_item_type it;
      it.operation   = op;
      it.sound_id    = snd;
      it.voice_index = idx;
      pending_items.push_back(it);
   endtask

   task automatic offer_item(input alloc_item_type it);
      offered_item         <= it;
      req_chan.valid       <= 1'b1;
      req_chan.operation   <= it.operation;
      req_chan.sound_id    <= it.sound_id;
      req_chan.voice_index <= it.voice_index;
   endtask

   task automatic report_mismatch(input string field, input logic [STEAL_W-1:0] got,
                                  input logic [STEAL_W-1:0] want);
      error_count++;
      $display("result %0d: %s is %0h, expected %0h", result_count, field, got, want);
   endtask

   // sender
   always @(posedge clock) begin : sender
      alloc_item_type next_item;
      int             gap;
      if (reset) begin
         req_chan.valid <= 1'b0;
         sender_wait    <= 0;
      end else if (req_chan.valid && req_chan.ready) begin
         expected_results.push_back(allocate_voice(offered_item));
         sent_count++;
         if (sent_count % 32 == 0) sender_calm = ($urandom_range(0, 3) == 0);
         gap = sender_calm ? 0 : $urandom_range(0, 4);
         if (gap == 0 && pending_items.size() != 0) begin
            next_item = pending_items.pop_front();
            offer_item(next_item);
         end else begin
            req_chan.valid <= 1'b0;
            sender_wait    <= (gap > 0) ? gap - 1 : 0;
         end
      end else if (!req_chan.valid) begin
         if (sender_wait != 0) begin
            sender_wait <= sender_wait - 1;
         end else if (pending_items.size() != 0) begin
            next_item = pending_items.pop_front();
            offer_item(next_item);
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin : receiver
      voice_result_type want;
      int               stall;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         receiver_wait  <= 0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         result_count++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected transfer, slot",
                            STEAL_W'(rsp_chan.granted_slot), '0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_chan.granted_slot !== want.granted_slot)
               report_mismatch("granted_slot", STEAL_W'(rsp_chan.granted_slot),
                               STEAL_W'(want.granted_slot));
            if (rsp_chan.granted_sound !== want.granted_sound)
               report_mismatch("granted_sound", STEAL_W'(rsp_chan.granted_sound),
                               STEAL_W'(want.granted_sound));
            if (rsp_chan.was_stolen !== want.was_stolen)
               report_mismatch("was_stolen", STEAL_W'(rsp_chan.was_stolen),
                               STEAL_W'(want.was_stolen));
            if (rsp_chan.steal_total !== want.steal_total)
               report_mismatch("steal_total", rsp_chan.steal_total, want.steal_total);
            if (rsp_chan.voices_busy !== want.voices_busy)
               report_mismatch("voices_busy", STEAL_W'(rsp_chan.voices_busy),
                               STEAL_W'(want.voices_busy));
         end
         if (result_count % 32 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
         // long hold-off so the block backs up and stalls its input
         if (result_count == 40 || result_count == 500) stall = HOLD_OFF_CYCLES;
         else stall = receiver_calm ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            receiver_wait  <= stall - 1;
         end
      end else if (!rsp_chan.ready) begin
         if (receiver_wait != 0) receiver_wait <= receiver_wait - 1;
         else rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int generated;
      int run_len;
      int trigger_pct;

      // fill every voice, sound ids at the extremes
      queue_item(OP_TRIGGER, 8'h00, 3'd7);
      queue_item(OP_TRIGGER, 8'hff, 3'd0);
      queue_item(OP_TRIGGER, 8'h55, 3'd5);
      queue_item(OP_TRIGGER, 8'haa, 3'd2);
      queue_item(OP_TRIGGER, 8'h01, 3'd1);
      queue_item(OP_TRIGGER, 8'h80, 3'd6);
      queue_item(OP_TRIGGER, 8'h7f, 3'd3);
      queue_item(OP_TRIGGER, 8'hfe, 3'd4);
      // all busy: steal the oldest twice
      queue_item(OP_TRIGGER, 8'h3c, 3'd0);
      queue_item(OP_TRIGGER, 8'hc3, 3'd7);
      // release, release of an idle voice, refill lowest free first
      queue_item(OP_RELEASE, 8'hff, 3'd7);
      queue_item(OP_RELEASE, 8'h5a, 3'd7);
      queue_item(OP_RELEASE, 8'h00, 3'd0);
      queue_item(OP_TRIGGER, 8'h12, 3'd3);
      queue_item(OP_TRIGGER, 8'h34, 3'd3);
      queue_item(OP_TRIGGER, 8'h56, 3'd3);
      queue_item(OP_RELEASE, 8'ha5, 3'd3);
      queue_item(OP_RELEASE, 8'h0f, 3'd3);
      queue_item(OP_RELEASE, 8'hf0, 3'd5);
      queue_item(OP_TRIGGER, 8'h99, 3'd0);
      queue_item(OP_TRIGGER, 8'h66, 3'd1);
      queue_item(OP_TRIGGER, 8'hee, 3'd2);

      // random runs that lean toward filling, churning or draining
      generated = 0;
      while (generated < RANDOM_ITEMS) begin
         run_len = $urandom_range(10, 60);
         case ($urandom_range(0, 2))
            0: trigger_pct = 20;
            1: trigger_pct = 55;
            default: trigger_pct = 85;
         endcase
         for (int k = 0; k < run_len && generated < RANDOM_ITEMS; k++) begin
            if ($urandom_range(1, 100) <= trigger_pct)
               queue_item(OP_TRIGGER, SOUND_W'($urandom_range(0, 255)),
                          INDEX_W'($urandom_range(0, 7)));
            else
               queue_item(OP_RELEASE, SOUND_W'($urandom_range(0, 255)),
                          INDEX_W'($urandom_range(0, 7)));
            generated++;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_chan.valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
